FILE: rtl/eivt_pkg.sv
// Shared types and constants for the eased interval valve timer.
// Used by eivt_ease and eased_interval_valve_timer; depends on nothing.

package eivt_pkg;

   localparam int unsigned THR_W      = 13;
   localparam int unsigned LONG_W     = 23;
   localparam int unsigned SHORT_W    = 22;
   localparam int unsigned OPEN_W     = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned HEAT_W     = 16;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned Q_W        = FRAC_W + 1;
   localparam int unsigned ACC_W      = 26;
   localparam int unsigned MCAND_W    = 24;
   localparam int unsigned PROD_W     = MCAND_W + Q_W;
   localparam int unsigned CNT_W      = 5;
   localparam int unsigned ADDR_W     = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 24;

   localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_W;

   localparam logic [THR_W-1:0]   LOW_THRESHOLD_RST  = THR_W'(2980);
   localparam logic [THR_W-1:0]   HIGH_THRESHOLD_RST = THR_W'(3900);
   localparam logic [LONG_W-1:0]  LONGEST_RST        = LONG_W'(1800000);
   localparam logic [SHORT_W-1:0] SHORTEST_RST       = SHORT_W'(300000);
   localparam logic [OPEN_W-1:0]  OPEN_TIME_RST      = OPEN_W'(5000);

   typedef enum logic [2:0] {
      REG_LOW_THRESHOLD  = 3'd0,
      REG_HIGH_THRESHOLD = 3'd1,
      REG_LONGEST        = 3'd2,
      REG_SHORTEST       = 3'd3,
      REG_OPEN_TIME      = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [THR_W-1:0]   low;
      logic [THR_W-1:0]   high;
      logic [LONG_W-1:0]  longest;
      logic [SHORT_W-1:0] shortest;
      logic [OPEN_W-1:0]  open_time;
   } eivt_cfg_type;

   typedef enum logic [1:0] {
      TS_IDLE,
      TS_DECIDE,
      TS_CALC,
      TS_EMIT
   } top_state_type;

   typedef enum logic [3:0] {
      EP_IDLE,
      EP_DEN,
      EP_NUM,
      EP_CMP,
      EP_DIV,
      EP_G,
      EP_MUL_GG,
      EP_MUL_G3,
      EP_E,
      EP_SPAN,
      EP_MUL_RED,
      EP_FIN
   } ease_phase_type;

endpackage

FILE: rtl/eivt_ease.sv
// Eased delay sequencer: one shared adder runs a restoring divider and three
// shift-add multiplies to give the cubic ease-out check delay.
// Depends on eivt_pkg.

module eivt_ease (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [eivt_pkg::HEAT_W-1:0]  heat,
   input  eivt_pkg::eivt_cfg_type              cfg,
   output logic                                done,
   output logic [eivt_pkg::LONG_W-1:0]         delay
);
   import eivt_pkg::*;

   localparam int unsigned REM_W = HEAT_W - 1;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_W - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(Q_W - 1);

   ease_phase_type     phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [THR_W-1:0]   den_ff, den_in;
   logic               ordered_ff, ordered_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [Q_W-1:0]     quo_ff, quo_in;
   logic [Q_W-1:0]     g_ff, g_in;
   logic [MCAND_W-1:0] mcand_ff, mcand_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic [ACC_W-1:0]   op_a, op_b, sum;
   logic               op_sub, neg;
   logic [ACC_W-1:0]   mul_a, mul_b;
   logic [PROD_W-1:0]  prod_step;
   logic [REM_W-1:0]   rem_dbl;

   assign sum = op_a + (op_b ^ {ACC_W{op_sub}}) + ACC_W'(op_sub);
   assign neg = sum[ACC_W-1];

   assign mul_a     = ACC_W'(prod_ff[PROD_W-1:Q_W]);
   assign mul_b     = prod_ff[0] ? ACC_W'(mcand_ff) : '0;
   assign prod_step = {1'b0, sum[MCAND_W-1:0], prod_ff[Q_W-1:1]};
   assign rem_dbl   = {rem_ff[REM_W-2:0], 1'b0};

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         EP_IDLE:    if (start) phase_in = EP_DEN;
         EP_DEN:     phase_in = EP_NUM;
         EP_NUM:     phase_in = EP_CMP;
         EP_CMP:     phase_in = (!ordered_ff || !neg) ? EP_G : EP_DIV;
         EP_DIV:     if (count_ff == DIV_LAST) phase_in = EP_G;
         EP_G:       phase_in = EP_MUL_GG;
         EP_MUL_GG:  if (count_ff == MUL_LAST) phase_in = EP_MUL_G3;
         EP_MUL_G3:  if (count_ff == MUL_LAST) phase_in = EP_E;
         EP_E:       phase_in = EP_SPAN;
         EP_SPAN:    phase_in = EP_MUL_RED;
         EP_MUL_RED: if (count_ff == MUL_LAST) phase_in = EP_FIN;
         EP_FIN:     phase_in = EP_IDLE;
         default:    phase_in = EP_IDLE;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      den_in     = den_ff;
      ordered_in = ordered_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      g_in       = g_ff;
      mcand_in   = mcand_ff;
      prod_in    = prod_ff;
      op_a       = '0;
      op_b       = '0;
      op_sub     = 1'b0;
      done       = 1'b0;
      delay      = sum[LONG_W-1:0];
      unique case (phase_ff)
         EP_IDLE: begin
         end
         EP_DEN: begin
            op_a       = ACC_W'(cfg.high);
            op_b       = ACC_W'(cfg.low);
            op_sub     = 1'b1;
            den_in     = sum[THR_W-1:0];
            ordered_in = !neg && (sum != '0);
         end
         EP_NUM: begin
            op_a   = {{(ACC_W-HEAT_W){heat[HEAT_W-1]}}, heat};
            op_b   = ACC_W'(cfg.low);
            op_sub = 1'b1;
            rem_in = sum[REM_W-1:0];
         end
         EP_CMP: begin
            op_a     = ACC_W'(rem_ff);
            op_b     = ACC_W'(den_ff);
            op_sub   = 1'b1;
            quo_in   = (!ordered_ff || !neg) ? Q_ONE : '0;
            count_in = '0;
         end
         EP_DIV: begin
            op_a     = ACC_W'(rem_dbl);
            op_b     = ACC_W'(den_ff);
            op_sub   = 1'b1;
            rem_in   = neg ? rem_dbl : sum[REM_W-1:0];
            quo_in   = {quo_ff[Q_W-2:0], !neg};
            count_in = count_ff + 1'b1;
         end
         EP_G: begin
            op_a     = ACC_W'(Q_ONE);
            op_b     = ACC_W'(quo_ff);
            op_sub   = 1'b1;
            g_in     = sum[Q_W-1:0];
            mcand_in = MCAND_W'(sum[Q_W-1:0]);
            prod_in  = PROD_W'(sum[Q_W-1:0]);
            count_in = '0;
         end
         EP_MUL_GG: begin
            op_a     = mul_a;
            op_b     = mul_b;
            prod_in  = prod_step;
            count_in = count_ff + 1'b1;
            if (count_ff == MUL_LAST) begin
               mcand_in = MCAND_W'(prod_step[FRAC_W+Q_W-1:FRAC_W]);
               prod_in  = PROD_W'(g_ff);
               count_in = '0;
            end
         end
         EP_MUL_G3: begin
            op_a     = mul_a;
            op_b     = mul_b;
            prod_in  = prod_step;
            count_in = count_ff + 1'b1;
            if (count_ff == MUL_LAST) begin
               mcand_in = MCAND_W'(prod_step[FRAC_W+Q_W-1:FRAC_W]);
               count_in = '0;
            end
         end
         EP_E: begin
            op_a   = ACC_W'(Q_ONE);
            op_b   = ACC_W'(mcand_ff);
            op_sub = 1'b1;
            g_in   = sum[Q_W-1:0];
         end
         EP_SPAN: begin
            op_a     = ACC_W'(cfg.longest);
            op_b     = ACC_W'(cfg.shortest);
            op_sub   = 1'b1;
            mcand_in = neg ? '0 : MCAND_W'(sum[LONG_W-1:0]);
            prod_in  = PROD_W'(g_ff);
            count_in = '0;
         end
         EP_MUL_RED: begin
            op_a     = mul_a;
            op_b     = mul_b;
            prod_in  = prod_step;
            count_in = count_ff + 1'b1;
            if (count_ff == MUL_LAST) begin
               mcand_in = MCAND_W'(prod_step[FRAC_W+LONG_W-1:FRAC_W]);
               count_in = '0;
            end
         end
         EP_FIN: begin
            op_a   = ACC_W'(cfg.longest);
            op_b   = ACC_W'(mcand_ff);
            op_sub = 1'b1;
            done   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= EP_IDLE;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff     <= den_in;
      ordered_ff <= ordered_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      g_ff       <= g_in;
      mcand_ff   <= mcand_in;
      prod_ff    <= prod_in;
   end

endmodule

FILE: rtl/eased_interval_valve_timer.sv
// Top level of the eased interval valve timer: stream ports, register port,
// timing state and result register. Depends on eivt_pkg and eivt_ease.
//
// Each request carries a millisecond timestamp, a heat index and two flags and
// produces exactly one response with the valve drive and the current check
// delay. The block takes one request at a time: req_tready is high only while
// it is idle, and a response still waiting on rsp_tready does not stop the
// next request from being taken. A request that opens the valve runs the
// eased delay through one shared 26-bit adder, which serves a 16-step divider
// and three 17-step shift-add multiplies; the divider is skipped when the heat
// index is at or above the high threshold or the thresholds are not ordered.
// Registers sit at byte addresses 0, 4, 8, 12 and 16 in the order low
// threshold, high threshold, longest period, shortest period, open time;
// write them only while no request is in flight.

module eased_interval_valve_timer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [31:0] time_ms, [47:32] heat_index, [48] force_close, [55:49] zero
   input  logic [eivt_pkg::REQ_DATA_W-1:0]       req_tdata,
   // [0] reading_ok
   input  logic [0:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] valve_open, [23:1] check_delay_ms
   output logic [eivt_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [eivt_pkg::ADDR_W-1:0]           csr_paddr,
   input  logic [eivt_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [eivt_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import eivt_pkg::*;

   localparam int unsigned HEAT_LSB  = TIME_W;
   localparam int unsigned FORCE_BIT = TIME_W + HEAT_W;

   eivt_cfg_type          cfg_ff, cfg_in;
   top_state_type         state_ff, state_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic signed [HEAT_W-1:0] heat_ff, heat_in;
   logic                  ok_ff, ok_in;
   logic                  fc_ff, fc_in;
   logic [TIME_W-1:0]     cycle_start_ff, cycle_start_in;
   logic [LONG_W-1:0]     delay_ff, delay_in;
   logic                  active_ff, active_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  csr_write;
   reg_index_type         csr_index;
   logic [TIME_W-1:0]     elapsed;
   logic                  due, open_due, heat_low, open_go, slot_free;
   logic                  ease_start, ease_done;
   logic [LONG_W-1:0]     ease_delay;

   eivt_ease u_ease (
      .clock (clock),
      .reset (reset),
      .start (ease_start),
      .heat  (heat_ff),
      .cfg   (cfg_ff),
      .done  (ease_done),
      .delay (ease_delay)
   );

   assign req_tready = (state_ff == TS_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   assign elapsed  = time_ff - cycle_start_ff;
   assign due      = elapsed >= TIME_W'(delay_ff);
   assign open_due = elapsed >= TIME_W'(cfg_ff.open_time);
   assign heat_low = heat_ff < $signed({{(HEAT_W-THR_W){1'b0}}, cfg_ff.low});
   assign open_go  = !fc_ff && ok_ff && !heat_low && !active_ff && due;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_LOW_THRESHOLD:  cfg_in.low       = csr_pwdata[THR_W-1:0];
            REG_HIGH_THRESHOLD: cfg_in.high      = csr_pwdata[THR_W-1:0];
            REG_LONGEST:        cfg_in.longest   = csr_pwdata[LONG_W-1:0];
            REG_SHORTEST:       cfg_in.shortest  = csr_pwdata[SHORT_W-1:0];
            REG_OPEN_TIME:      cfg_in.open_time = csr_pwdata[OPEN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_LOW_THRESHOLD:  csr_prdata = CSR_DATA_W'(cfg_ff.low);
         REG_HIGH_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.high);
         REG_LONGEST:        csr_prdata = CSR_DATA_W'(cfg_ff.longest);
         REG_SHORTEST:       csr_prdata = CSR_DATA_W'(cfg_ff.shortest);
         REG_OPEN_TIME:      csr_prdata = CSR_DATA_W'(cfg_ff.open_time);
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TS_IDLE:   if (accept) state_in = TS_DECIDE;
         TS_DECIDE: state_in = open_go ? TS_CALC : TS_EMIT;
         TS_CALC:   if (ease_done) state_in = TS_EMIT;
         TS_EMIT:   if (slot_free) state_in = TS_IDLE;
         default:   state_in = TS_IDLE;
      endcase
   end

   always_comb begin
      time_in        = time_ff;
      heat_in        = heat_ff;
      ok_in          = ok_ff;
      fc_in          = fc_ff;
      cycle_start_in = cycle_start_ff;
      delay_in       = delay_ff;
      active_in      = active_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      ease_start     = 1'b0;
      unique case (state_ff)
         TS_IDLE: begin
            if (accept) begin
               time_in = req_tdata[TIME_W-1:0];
               heat_in = req_tdata[HEAT_LSB+HEAT_W-1:HEAT_LSB];
               ok_in   = req_tuser[0];
               fc_in   = req_tdata[FORCE_BIT];
            end
         end
         TS_DECIDE: begin
            if (fc_ff) begin
               active_in = 1'b0;
            end else if (!ok_ff || heat_low) begin
               active_in = 1'b0;
               if (due) begin
                  cycle_start_in = time_ff;
                  delay_in       = cfg_ff.longest;
               end
            end else if (open_go) begin
               ease_start = 1'b1;
            end else if (active_ff && open_due) begin
               active_in = 1'b0;
            end
         end
         TS_CALC: begin
            if (ease_done) begin
               delay_in       = ease_delay;
               cycle_start_in = time_ff;
               active_in      = (cfg_ff.open_time != '0);
            end
         end
         TS_EMIT: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {delay_ff, active_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= TS_IDLE;
         cfg_ff.low         <= LOW_THRESHOLD_RST;
         cfg_ff.high        <= HIGH_THRESHOLD_RST;
         cfg_ff.longest     <= LONGEST_RST;
         cfg_ff.shortest    <= SHORTEST_RST;
         cfg_ff.open_time   <= OPEN_TIME_RST;
         cycle_start_ff     <= '0;
         delay_ff           <= '0;
         active_ff          <= 1'b0;
         rsp_tvalid_ff      <= 1'b0;
      end else begin
         state_ff           <= state_in;
         cfg_ff             <= cfg_in;
         cycle_start_ff     <= cycle_start_in;
         delay_ff           <= delay_in;
         active_ff          <= active_in;
         rsp_tvalid_ff      <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff     <= time_in;
      heat_ff     <= heat_in;
      ok_ff       <= ok_in;
      fc_ff       <= fc_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      ease_done |-> (state_ff == TS_CALC))
      else $error("eased delay finished outside the calculation state");

   a_open_from_calc: assert property (@(posedge clock) disable iff (reset)
      $rose(active_ff) |-> $past(state_ff == TS_CALC))
      else $error("valve opened without an eased delay");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == TS_EMIT))
      else $error("response raised outside the emit state");

   a_delay_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(delay_ff)) |->
         ($past(state_ff == TS_DECIDE) || $past(state_ff == TS_CALC)))
      else $error("check delay changed outside a decision");
`endif

endmodule
